// ----- rtl/nnr_pkg.sv -----
// ----------------------------------------------------------------------------
// nnr_pkg
// Shared widths, constants and types of the nearest neighbor ratio block.
// ----------------------------------------------------------------------------
package nnr_pkg;

    localparam int COMP_W         = 16;
    localparam int SIGN_W         = 2;
    localparam int SQ_W           = 32;
    localparam int CHUNK_W        = 34;
    localparam int DIST_W         = 38;
    localparam int OUT_IDX_W      = 12;
    localparam int N_LANES        = 4;
    localparam int MAX_MODELS_DEF = 4096;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef struct packed {
        logic close;
        logic last;
        logic sign_eq;
    } t_item_flags;

    typedef struct packed {
        logic              last;
        logic              sign_eq;
        logic [DIST_W-1:0] sq_dist;
    } t_closed;

endpackage

// ----- rtl/descriptor_nearest_neighbor_ratio.sv -----
// ----------------------------------------------------------------------------
// descriptor_nearest_neighbor_ratio
// Brute-force nearest neighbor search with the ratio test for one query
// descriptor against a stream of model descriptors.
//
//   Channel  Direction  Handshake            Payload
//   input    in         i_valid / o_stall    4 query, 4 model comps, signs, marks
//   result   out        o_valid / i_stall    match flag, index, best distance
//
// One item is taken every cycle while o_stall is low; four lanes square the component differences.
// The set end passes the lane, chunk sum, record and capture registers to the output.
// o_stall rises only while a result is held and another set end must wait.
// Reset is synchronous and clears all search state.
// ----------------------------------------------------------------------------
module descriptor_nearest_neighbor_ratio
    import nnr_pkg::*;
#(
    parameter int MAX_MODELS = MAX_MODELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [COMP_W-1:0]    i_query_c0,
    input  logic signed [COMP_W-1:0]    i_query_c1,
    input  logic signed [COMP_W-1:0]    i_query_c2,
    input  logic signed [COMP_W-1:0]    i_query_c3,
    input  logic signed [COMP_W-1:0]    i_model_c0,
    input  logic signed [COMP_W-1:0]    i_model_c1,
    input  logic signed [COMP_W-1:0]    i_model_c2,
    input  logic signed [COMP_W-1:0]    i_model_c3,
    input  logic signed [SIGN_W-1:0]    i_model_sign,
    input  logic signed [SIGN_W-1:0]    i_query_sign,
    input  logic                        i_end_of_descriptor,
    input  logic                        i_end_of_models,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_match_found,
    output logic [OUT_IDX_W-1:0]        o_neighbor_index,
    output logic [DIST_W-1:0]           o_best_distance
);

    localparam int IDX_W = (MAX_MODELS > 2) ? $clog2(MAX_MODELS) : 1;

    logic signed [COMP_W-1:0] w_q [N_LANES];
    logic signed [COMP_W-1:0] w_m [N_LANES];
    logic        [SQ_W-1:0]   w_sq [N_LANES];
    logic                     r_va;
    t_item_flags              r_flags;
    logic                     w_en_a;
    logic                     w_blk_b;
    logic                     w_vc;
    t_closed                  w_rec;
    logic [IDX_W-1:0]         w_idx;
    logic                     w_blk_c;

    assign w_q[0] = i_query_c0;
    assign w_q[1] = i_query_c1;
    assign w_q[2] = i_query_c2;
    assign w_q[3] = i_query_c3;
    assign w_m[0] = i_model_c0;
    assign w_m[1] = i_model_c1;
    assign w_m[2] = i_model_c2;
    assign w_m[3] = i_model_c3;

    assign o_stall = r_va && w_blk_b;
    assign w_en_a  = !o_stall;

    genvar g;
    generate
        for (g = 0; g < N_LANES; g++) begin : g_lane
            nnr_lane u_lane (
                .i_clk (i_clk),
                .i_en  (w_en_a),
                .i_a   (w_q[g]),
                .i_b   (w_m[g]),
                .o_sq  (w_sq[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (w_en_a) begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_flags.close   <= i_end_of_descriptor || i_end_of_models;
            r_flags.last    <= i_end_of_models;
            r_flags.sign_eq <= (i_model_sign == i_query_sign);
        end
    end

    nnr_accum #(
        .MAX_MODELS (MAX_MODELS),
        .IDX_W      (IDX_W)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_va),
        .i_flags (r_flags),
        .i_sq    (w_sq),
        .o_block (w_blk_b),
        .o_valid (w_vc),
        .o_rec   (w_rec),
        .o_idx   (w_idx),
        .i_block (w_blk_c)
    );

    nnr_select #(
        .IDX_W (IDX_W)
    ) u_select (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_vc),
        .i_rec            (w_rec),
        .i_idx            (w_idx),
        .o_block          (w_blk_c),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_match_found    (o_match_found),
        .o_neighbor_index (o_neighbor_index),
        .o_best_distance  (o_best_distance)
    );

endmodule

// ----- rtl/nnr_lane.sv -----
// ----------------------------------------------------------------------------
// nnr_lane
// One lane: registered square of the difference of two components.
// ----------------------------------------------------------------------------
module nnr_lane
    import nnr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [COMP_W-1:0] i_a,
    input  logic signed [COMP_W-1:0] i_b,
    output logic        [SQ_W-1:0]   o_sq
);

    logic signed [COMP_W:0]     w_diff;
    logic signed [2*COMP_W+1:0] w_prod;
    logic        [SQ_W-1:0]     r_sq;

    assign w_diff = (COMP_W+1)'(i_a) - (COMP_W+1)'(i_b);
    assign w_prod = w_diff * w_diff;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= w_prod[SQ_W-1:0];
        end
    end

    assign o_sq = r_sq;

endmodule

// ----- rtl/nnr_accum.sv -----
// ----------------------------------------------------------------------------
// nnr_accum
// Merges the lane squares into one chunk sum, accumulates the saturated
// distance of each model and hands each closed model to the selection stage.
// ----------------------------------------------------------------------------
module nnr_accum
    import nnr_pkg::*;
#(
    parameter int MAX_MODELS = MAX_MODELS_DEF,
    parameter int IDX_W      = (MAX_MODELS > 2) ? $clog2(MAX_MODELS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_item_flags       i_flags,
    input  logic [SQ_W-1:0]   i_sq [N_LANES],
    output logic              o_block,
    output logic              o_valid,
    output t_closed           o_rec,
    output logic [IDX_W-1:0]  o_idx,
    input  logic              i_block
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_MODELS - 1);

    logic                  r_vb;
    t_item_flags           r_flags;
    logic [CHUNK_W-1:0]    r_chunk;
    logic [CHUNK_W-1:0]    w_tree;
    logic [DIST_W-1:0]     r_run;
    logic [DIST_W:0]       w_total;
    logic [DIST_W-1:0]     w_sat;
    logic [IDX_W-1:0]      r_count;
    logic                  r_vc;
    t_closed               r_rec;
    logic [IDX_W-1:0]      r_idx;
    logic                  w_proc;

    assign w_tree = (CHUNK_W'(i_sq[0]) + CHUNK_W'(i_sq[1]))
                  + (CHUNK_W'(i_sq[2]) + CHUNK_W'(i_sq[3]));

    assign o_block = r_vb && r_flags.close && i_block;
    assign w_proc  = r_vb && !o_block;
    assign w_total = (DIST_W+1)'(r_run) + (DIST_W+1)'(r_chunk);
    assign w_sat   = w_total[DIST_W] ? DIST_MAX : w_total[DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb    <= 1'b0;
            r_vc    <= 1'b0;
            r_run   <= '0;
            r_count <= '0;
        end else begin
            if (!o_block) begin
                r_vb <= i_valid;
            end
            if (!i_block) begin
                r_vc <= w_proc && r_flags.close;
            end
            if (w_proc) begin
                if (r_flags.close) begin
                    r_run <= '0;
                    if (r_flags.last) begin
                        r_count <= '0;
                    end else begin
                        r_count <= (r_count == LAST_IDX) ? '0 : r_count + IDX_W'(1);
                    end
                end else begin
                    r_run <= w_sat;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_block) begin
            r_flags <= i_flags;
            r_chunk <= w_tree;
        end
        if (w_proc && r_flags.close && !i_block) begin
            r_rec.last    <= r_flags.last;
            r_rec.sign_eq <= r_flags.sign_eq;
            r_rec.sq_dist <= w_sat;
            r_idx         <= r_count;
        end
    end

    assign o_valid = r_vc;
    assign o_rec   = r_rec;
    assign o_idx   = r_idx;

endmodule

// ----- rtl/nnr_select.sv -----
// ----------------------------------------------------------------------------
// nnr_select
// Keeps the best and second-best distances, captures them at the end of a
// set and applies the ratio test into the output register.
// ----------------------------------------------------------------------------
module nnr_select
    import nnr_pkg::*;
#(
    parameter int IDX_W = OUT_IDX_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_closed              i_rec,
    input  logic [IDX_W-1:0]     i_idx,
    output logic                 o_block,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_match_found,
    output logic [OUT_IDX_W-1:0] o_neighbor_index,
    output logic [DIST_W-1:0]    o_best_distance
);

    logic [DIST_W-1:0]           r_best;
    logic [DIST_W-1:0]           r_second;
    logic [IDX_W-1:0]            r_bidx;
    logic                        r_have;
    logic [DIST_W-1:0]           n_best;
    logic [DIST_W-1:0]           n_second;
    logic [IDX_W-1:0]            n_bidx;
    logic                        n_have;
    logic                        r_vd;
    logic [DIST_W-1:0]           r_cap_best;
    logic [DIST_W-1:0]           r_cap_second;
    logic [IDX_W-1:0]            r_cap_idx;
    logic                        r_cap_have;
    logic                        r_out_valid;
    logic                        r_match;
    logic [OUT_IDX_W-1:0]        r_nidx;
    logic [DIST_W-1:0]           r_bdist;
    logic                        w_blk_d;
    logic                        w_proc;
    logic                        w_load;
    logic [DIST_W+2:0]           w_five;
    logic [DIST_W+2:0]           w_three;
    logic                        w_match;
    logic [IDX_W+OUT_IDX_W-1:0]  w_idx_ext;

    assign w_blk_d = r_vd && r_out_valid && i_stall;
    assign o_block = i_valid && i_rec.last && w_blk_d;
    assign w_proc  = i_valid && !o_block;
    assign w_load  = r_vd && !w_blk_d;

    always_comb begin
        n_best   = r_best;
        n_second = r_second;
        n_bidx   = r_bidx;
        n_have   = r_have;
        if (i_rec.sign_eq) begin
            if (i_rec.sq_dist < r_best) begin
                n_second = r_best;
                n_best   = i_rec.sq_dist;
                n_bidx   = i_idx;
                n_have   = 1'b1;
            end else if (i_rec.sq_dist < r_second) begin
                n_second = i_rec.sq_dist;
            end
        end
    end

    assign w_five    = (DIST_W+3)'({r_cap_best, 2'b00}) + (DIST_W+3)'(r_cap_best);
    assign w_three   = (DIST_W+3)'({r_cap_second, 1'b0}) + (DIST_W+3)'(r_cap_second);
    assign w_match   = r_cap_have && (w_five < w_three);
    assign w_idx_ext = (IDX_W+OUT_IDX_W)'(r_cap_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best      <= DIST_MAX;
            r_second    <= DIST_MAX;
            r_bidx      <= '0;
            r_have      <= 1'b0;
            r_vd        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_proc) begin
                if (i_rec.last) begin
                    r_best   <= DIST_MAX;
                    r_second <= DIST_MAX;
                    r_bidx   <= '0;
                    r_have   <= 1'b0;
                end else begin
                    r_best   <= n_best;
                    r_second <= n_second;
                    r_bidx   <= n_bidx;
                    r_have   <= n_have;
                end
            end
            if (!w_blk_d) begin
                r_vd <= w_proc && i_rec.last;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && i_rec.last && !w_blk_d) begin
            r_cap_best   <= n_best;
            r_cap_second <= n_second;
            r_cap_idx    <= n_bidx;
            r_cap_have   <= n_have;
        end
        if (w_load) begin
            r_match <= w_match;
            r_nidx  <= w_match ? w_idx_ext[OUT_IDX_W-1:0] : '0;
            r_bdist <= r_cap_best;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_match_found    = r_match;
    assign o_neighbor_index = r_nidx;
    assign o_best_distance  = r_bdist;

endmodule

// ----- rtl/nnr_checker.sv -----
// ----------------------------------------------------------------------------
// nnr_checker
// Port-level checks of the nearest neighbor ratio block.
// ----------------------------------------------------------------------------
module nnr_checker
    import nnr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_valid,
    input  logic                 i_stall,
    input  logic                 o_match_found,
    input  logic [OUT_IDX_W-1:0] o_neighbor_index,
    input  logic [DIST_W-1:0]    o_best_distance
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result valid right after reset.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_match_found)
            && $stable(o_neighbor_index) && $stable(o_best_distance))
        else $error("Stalled result item changed.");

    a_no_match_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_match_found |-> o_neighbor_index == '0)
        else $error("Index is not zero without a match.");

    a_match_distance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_match_found |-> o_best_distance != DIST_MAX)
        else $error("Match reported with a saturated best distance.");

endmodule

bind descriptor_nearest_neighbor_ratio nnr_checker u_nnr_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the nearest neighbor ratio search against an in-bench model of the
// distance accumulation, the best and second-best tracking and the ratio test.
// A directed opening covers the field extremes, the sign patterns, an unmarked
// set end, an empty search and saturation. Random sets follow with random
// idling on both channels, then a calm stretch without idling.
// ----------------------------------------------------------------------------
module testbench;
    import nnr_pkg::*;

    localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'b00;
    localparam logic [SIGN_W-1:0] SIGN_POS  = 2'b01;
    localparam logic [SIGN_W-1:0] SIGN_BAD  = 2'b10;
    localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'b11;

    localparam int NOISY_ITEMS   = 1000;
    localparam int CALM_ITEMS    = 100;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct packed {
        logic [N_LANES-1:0][COMP_W-1:0] query;
        logic [N_LANES-1:0][COMP_W-1:0] model;
        logic [SIGN_W-1:0]              model_sign;
        logic [SIGN_W-1:0]              query_sign;
        logic                           last_chunk;
        logic                           last_model;
    } t_nn_item;

    typedef struct packed {
        logic                 match;
        logic [OUT_IDX_W-1:0] index;
        logic [DIST_W-1:0]    sq_dist;
    } t_nn_result;

    class nn_ratio_scoreboard;
        logic [DIST_W-1:0] partial_dist;
        logic [DIST_W-1:0] nearest_dist;
        logic [DIST_W-1:0] runner_up_dist;
        int                nearest_idx;
        int                model_no;
        bit                found_nearest;
        t_nn_result        expected_q[$];
        int                errors = 0;
        int                n_items = 0;
        int                n_results = 0;
        int                n_matches = 0;
        int                n_unqualified = 0;

        function new();
            restart();
        endfunction

        function void restart();
            partial_dist   = '0;
            nearest_dist   = DIST_MAX;
            runner_up_dist = DIST_MAX;
            nearest_idx    = 0;
            model_no       = 0;
            found_nearest  = 1'b0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_item(t_nn_item it);
            longint unsigned total;
            longint          d;
            t_nn_result      res;
            n_items++;
            total = partial_dist;
            for (int k = 0; k < N_LANES; k++) begin
                d = longint'($signed(it.query[k])) - longint'($signed(it.model[k]));
                total += d * d;
            end
            if (total > DIST_MAX) begin
                total = DIST_MAX;
            end
            partial_dist = total[DIST_W-1:0];
            if (it.last_chunk || it.last_model) begin
                if (it.model_sign == it.query_sign) begin
                    if (partial_dist < nearest_dist) begin
                        runner_up_dist = nearest_dist;
                        nearest_dist   = partial_dist;
                        nearest_idx    = model_no;
                        found_nearest  = 1'b1;
                    end else if (partial_dist < runner_up_dist) begin
                        runner_up_dist = partial_dist;
                    end
                end
                partial_dist = '0;
                model_no = (model_no + 1 >= MAX_MODELS_DEF) ? 0 : model_no + 1;
            end
            if (it.last_model) begin
                res.match   = found_nearest &&
                              (5 * longint'(nearest_dist) < 3 * longint'(runner_up_dist));
                res.index   = res.match ? nearest_idx[OUT_IDX_W-1:0] : '0;
                res.sq_dist = nearest_dist;
                expected_q  = {expected_q, res};
                restart();
            end
        endfunction

        function void check_result(t_nn_result got);
            t_nn_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: match %0b index %0d distance %0d",
                         $time, got.match, got.index, got.sq_dist);
                return;
            end
            want = expected_q.pop_front();
            n_results++;
            if (want.match) n_matches++;
            if (want.sq_dist == DIST_MAX) n_unqualified++;
            if (got.match !== want.match) begin
                errors++;
                $display("%0t: match_found mismatch: expected %0b, actual %0b",
                         $time, want.match, got.match);
            end
            if (got.index !== want.index) begin
                errors++;
                $display("%0t: neighbor_index mismatch: expected %0d, actual %0d",
                         $time, want.index, got.index);
            end
            if (got.sq_dist !== want.sq_dist) begin
                errors++;
                $display("%0t: best_distance mismatch: expected %0d, actual %0d",
                         $time, want.sq_dist, got.sq_dist);
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic signed [COMP_W-1:0] i_query_c0;
    logic signed [COMP_W-1:0] i_query_c1;
    logic signed [COMP_W-1:0] i_query_c2;
    logic signed [COMP_W-1:0] i_query_c3;
    logic signed [COMP_W-1:0] i_model_c0;
    logic signed [COMP_W-1:0] i_model_c1;
    logic signed [COMP_W-1:0] i_model_c2;
    logic signed [COMP_W-1:0] i_model_c3;
    logic signed [SIGN_W-1:0] i_model_sign;
    logic signed [SIGN_W-1:0] i_query_sign;
    logic                     i_end_of_descriptor;
    logic                     i_end_of_models;
    logic                     o_valid;
    logic                     i_stall;
    logic                     o_match_found;
    logic [OUT_IDX_W-1:0]     o_neighbor_index;
    logic [DIST_W-1:0]        o_best_distance;

    nn_ratio_scoreboard board = new;
    bit quiet = 1'b0;
    bit sender_idles = 1'b1;

    descriptor_nearest_neighbor_ratio dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_query_c0          (i_query_c0),
        .i_query_c1          (i_query_c1),
        .i_query_c2          (i_query_c2),
        .i_query_c3          (i_query_c3),
        .i_model_c0          (i_model_c0),
        .i_model_c1          (i_model_c1),
        .i_model_c2          (i_model_c2),
        .i_model_c3          (i_model_c3),
        .i_model_sign        (i_model_sign),
        .i_query_sign        (i_query_sign),
        .i_end_of_descriptor (i_end_of_descriptor),
        .i_end_of_models     (i_end_of_models),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_match_found       (o_match_found),
        .o_neighbor_index    (o_neighbor_index),
        .o_best_distance     (o_best_distance)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_result({o_match_found, o_neighbor_index, o_best_distance});
        end
    end

    initial begin
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 19) == 0) begin
                repeat ($urandom_range(20, 60)) @(posedge i_clk);
            end else begin
                @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input t_nn_item it);
        if (!quiet && sender_idles && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid             <= 1'b1;
        i_query_c0          <= it.query[0];
        i_query_c1          <= it.query[1];
        i_query_c2          <= it.query[2];
        i_query_c3          <= it.query[3];
        i_model_c0          <= it.model[0];
        i_model_c1          <= it.model[1];
        i_model_c2          <= it.model[2];
        i_model_c3          <= it.model[3];
        i_model_sign        <= it.model_sign;
        i_query_sign        <= it.query_sign;
        i_end_of_descriptor <= it.last_chunk;
        i_end_of_models     <= it.last_model;
        do @(posedge i_clk); while (o_stall);
        board.note_item(it);
    endtask

    function automatic t_nn_item chunk_of(logic [N_LANES*COMP_W-1:0] q,
                                          logic [N_LANES*COMP_W-1:0] m,
                                          logic [SIGN_W-1:0] m_sign,
                                          logic [SIGN_W-1:0] q_sign,
                                          logic last_chunk, logic last_model);
        t_nn_item it;
        it.query      = q;
        it.model      = m;
        it.model_sign = m_sign;
        it.query_sign = q_sign;
        it.last_chunk = last_chunk;
        it.last_model = last_model;
        return it;
    endfunction

    function automatic logic [COMP_W-1:0] rand_comp();
        case ($urandom_range(0, 7))
            0: return COMP_W'($urandom);
            1: begin
                case ($urandom_range(0, 3))
                    0: return 16'h4000;
                    1: return 16'hc000;
                    2: return 16'h7fff;
                    default: return 16'h8000;
                endcase
            end
            default: return COMP_W'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic logic [COMP_W-1:0] near_comp(logic [COMP_W-1:0] q, int spread);
        if (spread < 0) begin
            return rand_comp();
        end
        return q + COMP_W'($urandom_range(0, 2 * spread) - spread);
    endfunction

    function automatic logic [SIGN_W-1:0] rand_sign();
        case ($urandom_range(0, 9))
            0: return SIGN_ZERO;
            1: return SIGN_BAD;
            2, 3, 4, 5: return SIGN_POS;
            default: return SIGN_NEG;
        endcase
    endfunction

    task automatic random_set();
        int                n_models;
        int                len;
        int                spread;
        bit                heavy;
        bit                unmarked;
        bit                at_end;
        logic [SIGN_W-1:0] q_sign;
        logic [SIGN_W-1:0] m_sign;
        t_nn_item          it;
        sender_idles = ($urandom_range(0, 2) != 0);
        n_models = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        q_sign   = rand_sign();
        unmarked = ($urandom_range(0, 3) == 0);
        for (int m = 0; m < n_models; m++) begin
            heavy  = ($urandom_range(0, 24) == 0);
            len    = heavy ? $urandom_range(15, 20) : $urandom_range(1, 6);
            m_sign = ($urandom_range(0, 9) < 7) ? q_sign : SIGN_W'($urandom);
            case ($urandom_range(0, 4))
                0: spread = 0;
                1: spread = 64;
                2: spread = 1024;
                3: spread = 8192;
                default: spread = -1;
            endcase
            for (int c = 0; c < len; c++) begin
                for (int k = 0; k < N_LANES; k++) begin
                    if (heavy) begin
                        it.query[k] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                        it.model[k] = ~it.query[k];
                    end else begin
                        it.query[k] = rand_comp();
                        it.model[k] = near_comp(it.query[k], spread);
                    end
                end
                at_end        = (c == len - 1);
                it.last_model = at_end && (m == n_models - 1);
                it.last_chunk = at_end && !(unmarked && it.last_model);
                it.model_sign = at_end ? m_sign : SIGN_W'($urandom);
                it.query_sign = at_end ? q_sign : SIGN_W'($urandom);
                send_item(it);
            end
        end
    endtask

    initial begin
        logic [N_LANES*COMP_W-1:0] base;
        int                        calm_start;
        i_rst_n             <= 1'b0;
        i_valid             <= 1'b0;
        i_query_c0          <= '0;
        i_query_c1          <= '0;
        i_query_c2          <= '0;
        i_query_c3          <= '0;
        i_model_c0          <= '0;
        i_model_c1          <= '0;
        i_model_c2          <= '0;
        i_model_c3          <= '0;
        i_model_sign        <= '0;
        i_query_sign        <= '0;
        i_end_of_descriptor <= 1'b0;
        i_end_of_models     <= 1'b0;
        base = {16'h0123, 16'hff00, 16'h0000, 16'h1000};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A single model with two lanes at the field extremes and two at half scale.
        send_item(chunk_of({16'h8000, 16'h7fff, 16'hc000, 16'h4000},
                           {16'h7fff, 16'h8000, 16'h4000, 16'hc000},
                           SIGN_POS, SIGN_POS, 1'b1, 1'b1));

        // The out-of-range sign pattern matches only itself.
        send_item(chunk_of(base, base, SIGN_BAD, SIGN_BAD, 1'b1, 1'b0));
        send_item(chunk_of(base, base, SIGN_POS, SIGN_BAD, 1'b1, 1'b0));
        send_item(chunk_of(base, ~base, SIGN_BAD, SIGN_BAD, 1'b1, 1'b1));

        // The set end closes the last model without its own end mark.
        send_item(chunk_of(base, {base[63:16], 16'h1064}, SIGN_NEG, SIGN_NEG, 1'b1, 1'b0));
        send_item(chunk_of(base, {base[63:16], 16'h103c}, SIGN_NEG, SIGN_NEG, 1'b0, 1'b0));
        send_item(chunk_of(base, {base[63:16], 16'h1032}, SIGN_NEG, SIGN_NEG, 1'b0, 1'b1));

        // No model qualifies.
        send_item(chunk_of(base, base, SIGN_ZERO, SIGN_NEG, 1'b1, 1'b1));

        // A saturated model cannot take the best place.
        for (int c = 0; c < 17; c++) begin
            send_item(chunk_of({4{16'h7fff}}, {4{16'h8000}}, SIGN_ZERO, SIGN_ZERO,
                               c == 16, 1'b0));
        end
        send_item(chunk_of(base, {base[63:16], 16'h1001}, SIGN_ZERO, SIGN_ZERO, 1'b1, 1'b1));

        while (board.n_items < NOISY_ITEMS) begin
            random_set();
        end
        quiet = 1'b1;
        calm_start = board.n_items;
        while (board.n_items < calm_start + CALM_ITEMS) begin
            random_set();
        end
        i_valid <= 1'b0;

        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Searched %0d items into %0d results: %0d matches, %0d with no qualifying model.",
                 board.n_items, board.n_results, board.n_matches, board.n_unqualified);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- descriptor_nearest_neighbor_ratio.f -----
rtl/nnr_pkg.sv
rtl/nnr_lane.sv
rtl/nnr_accum.sv
rtl/nnr_select.sv
rtl/descriptor_nearest_neighbor_ratio.sv
rtl/nnr_checker.sv
tb/testbench.sv
